### rtl/nfea_pkg.sv
// Package with the shared types and status codes of the next-fit extent allocator.
`timescale 1ns / 1ps
package nfea_pkg;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_NOFIT = 3'd1,
        ST_BAD   = 3'd2,
        ST_OOB   = 3'd3,
        ST_FREE  = 3'd4,
        ST_FULL  = 3'd5
    } status_t;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // One extent table entry: start and length, 11 bits each.
    typedef struct packed {
        logic [10:0] start;
        logic [10:0] length;
    } extent_t;

endpackage

### rtl/nfea_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module nfea_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/next_fit_extent_allocator_top.sv
// Top level of the next-fit extent allocator: control sequencer around the extent table RAM.
//
//  channel | dir | fields (tuser / tdata from bit 0)                     | handshake
//  s_      | in  | tuser: action; tdata: request_size, release_address   | s_tvalid/s_tready
//  m_      | out | tdata: status[2:0], overlap_warning, granted_address  | m_tvalid/m_tready
//
// One word is worked on at a time. Each table entry searched is read, then
// checked, and each entry moved by an insert or removal is read, then written.
// A word rejected on its fields alone goes straight to the output, and an
// exact-fit allocate skips the final write. Reset is synchronous and
// restores one extent covering the whole pool. A stalled result is held in the
// output register, and the next input word is taken only once it has been sent.
`timescale 1ns / 1ps
module next_fit_extent_allocator_top
    import nfea_pkg::*;
#(
    parameter int POOL_SIZE   = 1024,
    parameter int MAX_EXTENTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // action
    input  logic [23:0] s_tdata,   // request_size, release_address, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status, overlap_warning, granted_address, zero fill
);

    localparam int IW = (MAX_EXTENTS > 2) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_EXTENTS);
    localparam logic [11:0] POOL = 12'(POOL_SIZE);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_AREAD, S_ACHECK, S_RREAD, S_RCHECK,
        S_SHL_RD, S_SHL_WR, S_SHR_RD, S_SHR_WR, S_FINAL, S_OUT
    } state_t;

    state_t       state_reg;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] rover_reg;
    logic         act_reg;
    logic [10:0]  size_reg, addr_reg;
    logic [CW-1:0] k_reg;      // search step / scan index
    logic [IW-1:0] idx_reg;    // entry being worked on
    logic [IW-1:0] ptr_reg;    // shift pointer
    logic [IW-1:0] last_reg;   // shift end
    extent_t      prev_reg;    // preceding extent during release scan
    logic         has_prev_reg;
    extent_t      wfinal_reg;  // entry written in S_FINAL, after any shift
    logic [IW-1:0] wfaddr_reg;
    logic [IW-1:0] rov_new_reg;
    logic [2:0]   st_reg;
    logic         warn_reg;
    logic [9:0]   grant_reg;

    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    extent_t       wr_data, rd_data;

    nfea_ram #(.WIDTH(22), .DEPTH(1 << IW)) u_table (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // Search index for allocate: rover plus step, wrapped at the count.
    logic [CW:0] asum;
    logic [IW-1:0] aidx;
    assign asum = (CW+1)'(rover_reg) + (CW+1)'(k_reg);
    assign aidx = (asum >= (CW+1)'(count_reg)) ? IW'(asum - (CW+1)'(count_reg)) : IW'(asum);

    // Release arithmetic on the current and preceding entries.
    logic [11:0] endr, endp, endn;
    assign endr = 12'(addr_reg) + 12'(size_reg);
    assign endp = 12'(prev_reg.start) + 12'(prev_reg.length);
    assign endn = 12'(rd_data.start) + 12'(rd_data.length);

    // Read address: search index, scan index, or shift source.
    always_comb begin
        rd_addr = '0;
        unique case (state_reg)
            S_AREAD:  rd_addr = aidx;
            S_RREAD:  rd_addr = IW'(k_reg);
            S_SHL_RD: rd_addr = IW'(ptr_reg + 1'b1);
            S_SHR_RD: rd_addr = IW'(ptr_reg - 1'b1);
            default:  rd_addr = '0;
        endcase
    end

    // Single write port: initial entry, in-place updates, shift moves, final entry.
    always_comb begin
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        unique case (state_reg)
            S_INIT: begin
                wr_en = 1'b1;
                wr_data.start = '0;
                wr_data.length = 11'(POOL_SIZE);
            end
            S_SHL_WR, S_SHR_WR: begin
                wr_en = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data;
            end
            S_FINAL: begin
                wr_en = 1'b1;
                wr_addr = wfaddr_reg;
                wr_data = wfinal_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {2'b0, grant_reg, warn_reg, st_reg};

    // Sequencer: one clocked block for state and registered results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            count_reg <= CW'(1);
            rover_reg <= '0;
            st_reg <= '0;
            warn_reg <= 1'b0;
            grant_reg <= '0;
        end else begin
            unique case (state_reg)
                S_INIT: state_reg <= S_IDLE;
                S_IDLE: if (s_tvalid) begin
                    act_reg <= s_tuser;
                    size_reg <= s_tdata[10:0];
                    addr_reg <= s_tdata[21:11];
                    k_reg <= '0;
                    has_prev_reg <= 1'b0;
                    warn_reg <= 1'b0;
                    grant_reg <= '0;
                    if (s_tdata[10:0] == 11'd0) begin
                        st_reg <= ST_BAD;
                        state_reg <= S_OUT;
                    end else if (s_tuser == ACT_ALLOC) begin
                        state_reg <= S_AREAD;
                    end else if (12'(s_tdata[21:11]) > POOL) begin
                        st_reg <= ST_BAD;
                        state_reg <= S_OUT;
                    end else if (12'(s_tdata[21:11]) + 12'(s_tdata[10:0]) > POOL) begin
                        st_reg <= ST_OOB;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_RREAD;
                    end
                end
                // Allocate search: each entry is read, then checked.
                S_AREAD: begin
                    if (k_reg >= count_reg) begin
                        st_reg <= ST_NOFIT;
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg <= aidx;
                        state_reg <= S_ACHECK;
                    end
                end
                S_ACHECK: begin
                    if (rd_data.length >= size_reg) begin
                        st_reg <= ST_OK;
                        grant_reg <= rd_data.start[9:0];
                        if (rd_data.length == size_reg) begin
                            // Remove the entry by shifting the tail down.
                            count_reg <= count_reg - 1'b1;
                            rov_new_reg <= (CW'(idx_reg) + 1'b1 < count_reg) ? idx_reg : '0;
                            ptr_reg <= idx_reg;
                            last_reg <= IW'(count_reg - 1'b1);
                            wfaddr_reg <= idx_reg;
                            wfinal_reg <= rd_data;
                            state_reg <= (CW'(idx_reg) + 1'b1 < count_reg) ? S_SHL_RD : S_OUT;
                            if (CW'(idx_reg) + 1'b1 >= count_reg) rover_reg <= '0;
                        end else begin
                            wfaddr_reg <= idx_reg;
                            wfinal_reg.start <= rd_data.start + size_reg;
                            wfinal_reg.length <= rd_data.length - size_reg;
                            rov_new_reg <= (CW'(idx_reg) + 1'b1 < count_reg) ?
                                           IW'(idx_reg + 1'b1) : '0;
                            state_reg <= S_FINAL;
                        end
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_AREAD;
                    end
                end
                // Release scan: first entry with start above the address.
                S_RREAD: state_reg <= S_RCHECK;
                S_RCHECK: begin
                    if (k_reg < count_reg && rd_data.start <= addr_reg) begin
                        prev_reg <= rd_data;
                        has_prev_reg <= 1'b1;
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_RREAD;
                    end else begin
                        // k_reg is j; rd_data is the next entry if k_reg < count.
                        st_reg <= ST_OK;
                        if (has_prev_reg && endp >= 12'(addr_reg)) begin
                            if (k_reg < count_reg && endr > endn) begin
                                st_reg <= ST_OOB; state_reg <= S_OUT;
                            end else if (endp > endr) begin
                                st_reg <= ST_FREE; state_reg <= S_OUT;
                            end else if (k_reg < count_reg && endr >= 12'(rd_data.start)) begin
                                warn_reg <= (endp > 12'(addr_reg)) ||
                                            (endr > 12'(rd_data.start));
                                wfinal_reg.start <= prev_reg.start;
                                wfinal_reg.length <= 11'(endn - 12'(prev_reg.start));
                                wfaddr_reg <= IW'(k_reg - 1'b1);
                                // Drop entry j by shifting the tail down.
                                count_reg <= count_reg - 1'b1;
                                ptr_reg <= IW'(k_reg);
                                last_reg <= IW'(count_reg - 1'b1);
                                begin
                                    if (CW'(rover_reg) > k_reg) begin
                                        rov_new_reg <= IW'(rover_reg - 1'b1);
                                    end else if (CW'(rover_reg) >= count_reg - 1'b1) begin
                                        rov_new_reg <= '0;
                                    end else begin
                                        rov_new_reg <= rover_reg;
                                    end
                                end
                                state_reg <= (k_reg + 1'b1 < count_reg) ? S_SHL_RD : S_FINAL;
                            end else begin
                                warn_reg <= (endp > 12'(addr_reg));
                                wfinal_reg.start <= prev_reg.start;
                                wfinal_reg.length <= 11'(endr - 12'(prev_reg.start));
                                wfaddr_reg <= IW'(k_reg - 1'b1);
                                rov_new_reg <= rover_reg;
                                state_reg <= S_FINAL;
                            end
                        end else if (k_reg < count_reg && endr > endn) begin
                            st_reg <= ST_OOB; state_reg <= S_OUT;
                        end else if (k_reg < count_reg && endr >= 12'(rd_data.start)) begin
                            warn_reg <= (endr > 12'(rd_data.start));
                            wfinal_reg.start <= addr_reg;
                            wfinal_reg.length <= 11'(endn - 12'(addr_reg));
                            wfaddr_reg <= IW'(k_reg);
                            rov_new_reg <= rover_reg;
                            state_reg <= S_FINAL;
                        end else if (count_reg >= CMAX) begin
                            st_reg <= ST_FULL; state_reg <= S_OUT;
                        end else begin
                            // Insert at j: shift the tail up.
                            wfinal_reg.start <= addr_reg;
                            wfinal_reg.length <= size_reg;
                            wfaddr_reg <= IW'(k_reg);
                            count_reg <= count_reg + 1'b1;
                            rov_new_reg <= (count_reg != '0 && CW'(rover_reg) >= k_reg) ?
                                           IW'(rover_reg + 1'b1) : rover_reg;
                            ptr_reg <= IW'(count_reg);
                            last_reg <= IW'(k_reg);
                            state_reg <= (count_reg > k_reg) ? S_SHR_RD : S_FINAL;
                        end
                    end
                end
                // Shift down: entry ptr+1 moves to ptr.
                S_SHL_RD: state_reg <= S_SHL_WR;
                S_SHL_WR: begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (IW'(ptr_reg + 1'b1) >= last_reg) begin
                        state_reg <= (act_reg == ACT_ALLOC) ? S_OUT : S_FINAL;
                        if (act_reg == ACT_ALLOC) rover_reg <= rov_new_reg;
                    end else begin
                        state_reg <= S_SHL_RD;
                    end
                end
                // Shift up: entry ptr-1 moves to ptr.
                S_SHR_RD: state_reg <= S_SHR_WR;
                S_SHR_WR: begin
                    ptr_reg <= ptr_reg - 1'b1;
                    state_reg <= (IW'(ptr_reg - 1'b1) <= last_reg) ? S_FINAL : S_SHR_RD;
                end
                S_FINAL: begin
                    rover_reg <= rov_new_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // A result word is never offered while an input word can be accepted.
    property p_no_overlap;
        @(posedge aclk) disable iff (!aresetn) !(m_tvalid && s_tready);
    endproperty
    assert property (p_no_overlap) else $error("result and input overlap");

    property p_count_range;
        @(posedge aclk) disable iff (!aresetn) count_reg <= CMAX;
    endproperty
    assert property (p_count_range) else $error("extent count out of range");

    property p_ok_nowarn_alloc;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && st_reg != ST_OK) |-> (!warn_reg && grant_reg == '0);
    endproperty
    assert property (p_ok_nowarn_alloc) else $error("failure with payload");

    property p_rover;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == S_IDLE && count_reg != '0) |-> (CW'(rover_reg) < count_reg);
    endproperty
    assert property (p_rover) else $error("rover beyond count");

endmodule
